// ----- design/lzwbe_pkg.sv -----
// shared types and constants of the lzw byte encoder
package lzwbe_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int OUT_CODE_BITS   = 12;
    localparam int EPOCH_BITS      = 4;
    localparam int FIRST_FREE_CODE = 256;
    localparam logic [15:0] HASH_MULT = 16'd40503;

    typedef struct packed {
        logic [OUT_CODE_BITS-1:0] code;
        logic                     last_code;
    } result_t;

endpackage

// ----- design/lzw_byte_encoder_unit.sv -----
// top level of the lzw byte encoder
//
// s_ channel: one message byte per transfer, s_end_of_message on the last byte.
// m_ channel: emitted codes, m_last_code on the final code of a message.
// The dictionary is a hashed table in one ram (HASH_SLOTS entries), probed
// linearly with one read per cycle. An item is probed from its home slot
// until its pair is found, a stale-epoch slot is met or all slots are read;
// a miss emits the prefix code and writes the new pair back if a slot and a
// code are free. The last code of a message is emitted in a final step.
// The table is cleared by an epoch tag carried in each entry; every 15th
// message, and after reset, a sweep rewrites all HASH_SLOTS entries, one per
// cycle, during which s_ready stays low.
// Codes wait in a two-entry queue; while m_ready is low the engine holds the
// pending code and stops taking bytes once the queue is full.
// Reset (aresetn low, synchronous) drops queued codes, clears the prefix,
// sets the next free code to 256 and starts the clearing sweep.
module lzw_byte_encoder_unit #(
    parameter int CODE_BITS  = 12,
    parameter int HASH_SLOTS = 8192
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [lzwbe_pkg::BYTE_BITS-1:0]         s_data_byte,
    input  logic                                    s_end_of_message,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [lzwbe_pkg::OUT_CODE_BITS-1:0]     m_code,
    output logic                                    m_last_code
);

    localparam int IDX_W = $clog2(HASH_SLOTS);
    localparam int ENT_W = lzwbe_pkg::EPOCH_BITS + 2*CODE_BITS + lzwbe_pkg::BYTE_BITS;

    logic               push_valid;
    logic               push_ready;
    lzwbe_pkg::result_t push_data;
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [ENT_W-1:0]   ram_wr_data;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [ENT_W-1:0]   ram_rd_data;

    lzwbe_engine #(
        .CODE_BITS  (CODE_BITS),
        .HASH_SLOTS (HASH_SLOTS)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_message (s_end_of_message),
        .push_valid       (push_valid),
        .push_data        (push_data),
        .push_ready       (push_ready),
        .ram_wr_en        (ram_wr_en),
        .ram_wr_addr      (ram_wr_addr),
        .ram_wr_data      (ram_wr_data),
        .ram_rd_addr      (ram_rd_addr),
        .ram_rd_data      (ram_rd_data)
    );

    lzwbe_ram #(
        .WIDTH (ENT_W),
        .DEPTH (HASH_SLOTS)
    ) u_dict_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lzwbe_out_fifo u_out_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .push_ready  (push_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code      (m_code),
        .m_last_code (m_last_code)
    );

endmodule

// ----- design/lzwbe_ram.sv -----
// generic simple dual-port ram with registered read
module lzwbe_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/lzwbe_out_fifo.sv -----
// two-entry result queue between the encoder engine and the m_ channel
module lzwbe_out_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push_valid,
    input  lzwbe_pkg::result_t        push_data,
    output logic                      push_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [lzwbe_pkg::OUT_CODE_BITS-1:0] m_code,
    output logic                      m_last_code
);

    lzwbe_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready  = (count_reg != 2'd2);
    assign m_valid     = (count_reg != 2'd0);
    assign m_code      = entry_reg[rd_ptr_reg].code;
    assign m_last_code = entry_reg[rd_ptr_reg].last_code;
    assign do_push     = push_valid && push_ready;
    assign do_pop      = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/lzwbe_engine.sv -----
// lzw control: hash probe, dictionary insert, epoch-based clearing
module lzwbe_engine #(
    parameter int CODE_BITS  = 12,
    parameter int HASH_SLOTS = 8192
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lzwbe_pkg::BYTE_BITS-1:0]      s_data_byte,
    input  logic                                 s_end_of_message,
    output logic                                 push_valid,
    output lzwbe_pkg::result_t                   push_data,
    input  logic                                 push_ready,
    output logic                                 ram_wr_en,
    output logic [$clog2(HASH_SLOTS)-1:0]        ram_wr_addr,
    output logic [lzwbe_pkg::EPOCH_BITS+2*CODE_BITS+lzwbe_pkg::BYTE_BITS-1:0] ram_wr_data,
    output logic [$clog2(HASH_SLOTS)-1:0]        ram_rd_addr,
    input  logic [lzwbe_pkg::EPOCH_BITS+2*CODE_BITS+lzwbe_pkg::BYTE_BITS-1:0] ram_rd_data
);

    localparam int IDX_W  = $clog2(HASH_SLOTS);
    localparam int KEY_W  = CODE_BITS + lzwbe_pkg::BYTE_BITS;
    localparam int ENT_W  = lzwbe_pkg::EPOCH_BITS + KEY_W + CODE_BITS;
    localparam int PROD_W = KEY_W + 16;
    localparam int EXT_W  = CODE_BITS + lzwbe_pkg::OUT_CODE_BITS;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PROBE  = 3'd2;
    localparam logic [2:0] ST_MISS   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [CODE_BITS:0] FIRST_CODE =
        (CODE_BITS+1)'(lzwbe_pkg::FIRST_FREE_CODE);
    localparam logic [lzwbe_pkg::EPOCH_BITS-1:0] EPOCH_FIRST =
        lzwbe_pkg::EPOCH_BITS'(1);

    logic [2:0]                          state_reg, state_next;
    logic [CODE_BITS-1:0]                prefix_reg, prefix_next;
    logic                                prefix_valid_reg, prefix_valid_next;
    logic [CODE_BITS:0]                  next_free_reg, next_free_next;
    logic [lzwbe_pkg::EPOCH_BITS-1:0]    epoch_reg, epoch_next;
    logic [lzwbe_pkg::BYTE_BITS-1:0]     byte_reg, byte_next;
    logic                                last_reg, last_next;
    logic [IDX_W-1:0]                    addr_reg, addr_next;
    logic [IDX_W-1:0]                    probe_cnt_reg, probe_cnt_next;
    logic                                slot_ok_reg, slot_ok_next;

    logic [KEY_W-1:0]                    key_in, key_held;
    logic [PROD_W-1:0]                   hash_prod;
    logic [lzwbe_pkg::EPOCH_BITS-1:0]    ent_epoch;
    logic [KEY_W-1:0]                    ent_key;
    logic [CODE_BITS-1:0]                ent_val;
    logic [EXT_W-1:0]                    prefix_ext;
    logic                                accept;

    assign key_in     = {prefix_reg, s_data_byte};
    assign key_held   = {prefix_reg, byte_reg};
    assign hash_prod  = PROD_W'(key_in) * PROD_W'(lzwbe_pkg::HASH_MULT);
    assign ent_val    = ram_rd_data[CODE_BITS-1:0];
    assign ent_key    = ram_rd_data[CODE_BITS+KEY_W-1:CODE_BITS];
    assign ent_epoch  = ram_rd_data[ENT_W-1 -: lzwbe_pkg::EPOCH_BITS];
    assign prefix_ext = EXT_W'(prefix_reg);
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;

    always_comb begin
        state_next        = state_reg;
        prefix_next       = prefix_reg;
        prefix_valid_next = prefix_valid_reg;
        next_free_next    = next_free_reg;
        epoch_next        = epoch_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        addr_next         = addr_reg;
        probe_cnt_next    = probe_cnt_reg;
        slot_ok_next      = slot_ok_reg;
        ram_rd_addr       = hash_prod[IDX_W-1:0];
        ram_wr_en         = 1'b0;
        ram_wr_addr       = addr_reg;
        ram_wr_data       = {epoch_reg, key_held, next_free_reg[CODE_BITS-1:0]};
        push_valid        = 1'b0;
        push_data.code    = prefix_ext[lzwbe_pkg::OUT_CODE_BITS-1:0];
        push_data.last_code = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = '0;
                addr_next   = addr_reg + IDX_W'(1);
                if (addr_reg == {IDX_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    byte_next = s_data_byte;
                    last_next = s_end_of_message;
                    if (!prefix_valid_reg) begin
                        prefix_next       = CODE_BITS'(s_data_byte);
                        prefix_valid_next = 1'b1;
                        state_next        = s_end_of_message ? ST_FINISH : ST_IDLE;
                    end else begin
                        addr_next      = hash_prod[IDX_W-1:0];
                        probe_cnt_next = '0;
                        state_next     = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                ram_rd_addr = addr_reg + IDX_W'(1);
                if (ent_epoch != epoch_reg) begin
                    slot_ok_next = 1'b1;
                    state_next   = ST_MISS;
                end else if (ent_key == key_held) begin
                    prefix_next = ent_val;
                    state_next  = last_reg ? ST_FINISH : ST_IDLE;
                end else if (probe_cnt_reg == {IDX_W{1'b1}}) begin
                    slot_ok_next = 1'b0;
                    state_next   = ST_MISS;
                end else begin
                    addr_next      = addr_reg + IDX_W'(1);
                    probe_cnt_next = probe_cnt_reg + IDX_W'(1);
                end
            end
            ST_MISS: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    if (slot_ok_reg && !next_free_reg[CODE_BITS]) begin
                        ram_wr_en      = 1'b1;
                        next_free_next = next_free_reg + (CODE_BITS+1)'(1);
                    end
                    prefix_next = CODE_BITS'(byte_reg);
                    state_next  = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                push_valid          = 1'b1;
                push_data.last_code = 1'b1;
                if (push_ready) begin
                    prefix_next       = '0;
                    prefix_valid_next = 1'b0;
                    next_free_next    = FIRST_CODE;
                    if (epoch_reg == {lzwbe_pkg::EPOCH_BITS{1'b1}}) begin
                        epoch_next = EPOCH_FIRST;
                        addr_next  = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        epoch_next = epoch_reg + EPOCH_FIRST;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            prefix_reg       <= '0;
            prefix_valid_reg <= 1'b0;
            next_free_reg    <= FIRST_CODE;
            epoch_reg        <= EPOCH_FIRST;
            addr_reg         <= '0;
        end else begin
            state_reg        <= state_next;
            prefix_reg       <= prefix_next;
            prefix_valid_reg <= prefix_valid_next;
            next_free_reg    <= next_free_next;
            epoch_reg        <= epoch_next;
            addr_reg         <= addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        probe_cnt_reg <= probe_cnt_next;
        slot_ok_reg   <= slot_ok_next;
    end

endmodule
